// File: hw/rtl/qrpt_pkg.sv
package qrpt_pkg;

  // Field widths
  localparam int CoordW = 32;   // Q16.16 points, position and results
  localparam int QuatW  = 16;   // Q2.14 quaternion components
  localparam int ProdW  = 2 * QuatW;

  // Datapath widths
  localparam int MatW  = ProdW + 2;      // 2*(ab +/- cd) at scale 2^28
  localparam int VecW  = CoordW + 1;     // p - t without saturation
  localparam int VlW   = 16;             // low digit of the split vector
  localparam int VhW   = VecW - VlW;     // high digit, signed
  localparam int PrdW  = MatW + VhW;     // one partial product
  localparam int SumW  = PrdW + 2;       // sum over three columns
  localparam int AccW  = SumW + 1;       // merged high and low sums
  localparam int RndSh = 12;             // 2^28 scale less the 2^16 digit
  localparam int RotW  = AccW - RndSh;   // rotated value in Q16.16 units
  localparam int FinW  = RotW + 1;       // after adding the translation

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(2048);

  // Register file
  localparam int NumRegs = 7;
  localparam int AddrW   = 5;

  localparam logic [2:0] RegPosX  = 3'd0;
  localparam logic [2:0] RegPosY  = 3'd1;
  localparam logic [2:0] RegPosZ  = 3'd2;
  localparam logic [2:0] RegQuatW = 3'd3;
  localparam logic [2:0] RegQuatX = 3'd4;
  localparam logic [2:0] RegQuatY = 3'd5;
  localparam logic [2:0] RegQuatZ = 3'd6;

  localparam logic signed [QuatW-1:0]  QuatOne = 16'sd16384;
  localparam logic signed [ProdW-1:0]  ProdOne = 32'sd268435456;
  localparam logic signed [MatW-1:0]   MatOne  = 34'sd268435456;

  localparam logic signed [CoordW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh8000_0000;

  typedef struct packed {
    logic                     cmd;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] result_x;
    logic signed [CoordW-1:0] result_y;
    logic signed [CoordW-1:0] result_z;
    logic                     saturated;
  } out_t;

endpackage

// File: hw/rtl/quaternion_rigid_point_transform.sv
// Result: done_o strobes for the beat taken with start once it has run through every pipeline stage.
// Throughput: one point per cycle; busy never rises, the six-stage pipeline always advances.
// Set by the 34x17 multiplier stage: nine row/column products, each split into two digits.
// Reset: asynchronous, active low; clears the valid bits, loads zero position and the unit
// quaternion. The receiver cannot stall, so no beat is ever held back.
module quaternion_rigid_point_transform
  import qrpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Command channel
  input  logic             start,
  output logic             busy,
  input  in_t              item_i,
  // Result channel
  output logic             done_o,
  output out_t             result_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] pos_q  [3];
  logic signed [QuatW-1:0]  quat_q [4];   // w, x, y, z
  logic                     cfg_we;
  logic [2:0]               cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = paddr[AddrW-1:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]  <= '0;
      pos_q[1]  <= '0;
      pos_q[2]  <= '0;
      quat_q[0] <= QuatOne;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegPosX:  pos_q[0]  <= pwdata;
        RegPosY:  pos_q[1]  <= pwdata;
        RegPosZ:  pos_q[2]  <= pwdata;
        RegQuatW: quat_q[0] <= pwdata[QuatW-1:0];
        RegQuatX: quat_q[1] <= pwdata[QuatW-1:0];
        RegQuatY: quat_q[2] <= pwdata[QuatW-1:0];
        RegQuatZ: quat_q[3] <= pwdata[QuatW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegPosX:  prdata = pos_q[0];
      RegPosY:  prdata = pos_q[1];
      RegPosZ:  prdata = pos_q[2];
      RegQuatW: prdata = {16'h0000, quat_q[0]};
      RegQuatX: prdata = {16'h0000, quat_q[1]};
      RegQuatY: prdata = {16'h0000, quat_q[2]};
      RegQuatZ: prdata = {16'h0000, quat_q[3]};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Rotation matrix, rebuilt from the quaternion in two register steps.
  // Step one forms the ten component products, step two the matrix at scale 2^28.
  // The inverse uses the conjugate, whose matrix is the transpose of this one,
  // so only the forward matrix is kept. Both steps reset to the identity, so a
  // command taken right after reset or right after a write sees the new matrix
  // by the time it reaches the multipliers.
  // ---------------------------------------------------------------------------
  logic signed [ProdW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [MatW-1:0]  mat_d [3][3];
  logic signed [MatW-1:0]  mat_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q <= ProdOne;
      xx_q <= '0;
      yy_q <= '0;
      zz_q <= '0;
      xy_q <= '0;
      xz_q <= '0;
      yz_q <= '0;
      wx_q <= '0;
      wy_q <= '0;
      wz_q <= '0;
    end else begin
      ww_q <= ProdW'(quat_q[0]) * ProdW'(quat_q[0]);
      xx_q <= ProdW'(quat_q[1]) * ProdW'(quat_q[1]);
      yy_q <= ProdW'(quat_q[2]) * ProdW'(quat_q[2]);
      zz_q <= ProdW'(quat_q[3]) * ProdW'(quat_q[3]);
      xy_q <= ProdW'(quat_q[1]) * ProdW'(quat_q[2]);
      xz_q <= ProdW'(quat_q[1]) * ProdW'(quat_q[3]);
      yz_q <= ProdW'(quat_q[2]) * ProdW'(quat_q[3]);
      wx_q <= ProdW'(quat_q[0]) * ProdW'(quat_q[1]);
      wy_q <= ProdW'(quat_q[0]) * ProdW'(quat_q[2]);
      wz_q <= ProdW'(quat_q[0]) * ProdW'(quat_q[3]);
    end
  end

  always_comb begin
    mat_d[0][0] = MatW'(ww_q) + MatW'(xx_q) - MatW'(yy_q) - MatW'(zz_q);
    mat_d[1][1] = MatW'(ww_q) - MatW'(xx_q) + MatW'(yy_q) - MatW'(zz_q);
    mat_d[2][2] = MatW'(ww_q) - MatW'(xx_q) - MatW'(yy_q) + MatW'(zz_q);
    // Off-diagonal terms are twice a sum that stays within 33 bits
    mat_d[0][1] = (MatW'(xy_q) - MatW'(wz_q)) <<< 1;
    mat_d[0][2] = (MatW'(xz_q) + MatW'(wy_q)) <<< 1;
    mat_d[1][0] = (MatW'(xy_q) + MatW'(wz_q)) <<< 1;
    mat_d[1][2] = (MatW'(yz_q) - MatW'(wx_q)) <<< 1;
    mat_d[2][0] = (MatW'(xz_q) - MatW'(wy_q)) <<< 1;
    mat_d[2][1] = (MatW'(yz_q) + MatW'(wx_q)) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat_q[r][c] <= (r == c) ? MatOne : '0;
        end
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Point pipeline. Valid bits advance every cycle; payload registers load
  // unconditionally and carry no reset.
  // ---------------------------------------------------------------------------
  logic [4:0] vld_q;    // stages 0..4
  logic       done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[3:0], start & ~busy};
      done_q <= vld_q[4];
    end
  end

  // Stage 0: capture the command beat
  in_t in_q;

  always_ff @(posedge clk_i) begin
    in_q <= item_i;
  end

  // Stage 1: subtract the translation for the inverse, split into two digits.
  // The high digit is the floor of v / 2^16, the low digit the unsigned rest.
  logic signed [CoordW-1:0] pt   [3];
  logic signed [VecW-1:0]   vec  [3];
  logic signed [VhW-1:0]    vh_q [3];
  logic        [VlW-1:0]    vl_q [3];
  logic                     cmd1_q;

  assign pt[0] = in_q.point_x;
  assign pt[1] = in_q.point_y;
  assign pt[2] = in_q.point_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec[i] = VecW'(pt[i]) - (in_q.cmd ? VecW'(pos_q[i]) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= in_q.cmd;
    for (int i = 0; i < 3; i++) begin
      vh_q[i] <= vec[i][VecW-1:VlW];
      vl_q[i] <= vec[i][VlW-1:0];
    end
  end

  // Stage 2: one product per matrix entry and digit. Transpose for the inverse.
  logic signed [MatW-1:0] msel  [3][3];
  logic signed [PrdW-1:0] ph_q  [3][3];
  logic signed [PrdW-1:0] pl_q  [3][3];
  logic signed [VhW-1:0]  vl_s  [3];
  logic                   cmd2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        msel[r][c] = cmd1_q ? mat_q[c][r] : mat_q[r][c];
      end
    end
    for (int i = 0; i < 3; i++) begin
      vl_s[i] = $signed({1'b0, vl_q[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q <= cmd1_q;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ph_q[r][c] <= PrdW'(msel[r][c]) * PrdW'(vh_q[c]);
        pl_q[r][c] <= PrdW'(msel[r][c]) * PrdW'(vl_s[c]);
      end
    end
  end

  // Stage 3: row sums of each digit
  logic signed [SumW-1:0] sh_q [3];
  logic signed [SumW-1:0] sl_q [3];
  logic                   cmd3_q;

  always_ff @(posedge clk_i) begin
    cmd3_q <= cmd2_q;
    for (int r = 0; r < 3; r++) begin
      sh_q[r] <= SumW'(ph_q[r][0]) + SumW'(ph_q[r][1]) + SumW'(ph_q[r][2]);
      sl_q[r] <= SumW'(pl_q[r][0]) + SumW'(pl_q[r][1]) + SumW'(pl_q[r][2]);
    end
  end

  // Stage 4: merge the digits at scale 2^-16, round half up to Q16.16
  logic signed [AccW-1:0] acc  [3];
  logic signed [RotW-1:0] rot_q [3];
  logic                   cmd4_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = AccW'(sh_q[r]) + AccW'(sl_q[r] >>> VlW) + RoundHalf;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd4_q <= cmd3_q;
    for (int r = 0; r < 3; r++) begin
      rot_q[r] <= acc[r][AccW-1:RndSh];
    end
  end

  // Stage 5: add the translation for the forward transform, then clip
  logic signed [FinW-1:0]   fin [3];
  logic signed [CoordW-1:0] clp [3];
  logic [2:0]               ovf;
  out_t                     result_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      fin[r] = FinW'(rot_q[r]) + (cmd4_q ? '0 : FinW'(pos_q[r]));
      // Out of range when the bits above the result do not all match its sign
      ovf[r] = (fin[r][FinW-1:CoordW-1] != '0) && (fin[r][FinW-1:CoordW-1] != '1);
      clp[r] = ovf[r] ? (fin[r][FinW-1] ? SatMin : SatMax) : fin[r][CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.result_x  <= clp[0];
    result_q.result_y  <= clp[1];
    result_q.result_z  <= clp[2];
    result_q.saturated <= |ovf;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  // Every captured beat leaves on done_o once it has passed the remaining pipeline stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##5 done_o)
    else $error("captured beat did not reach the result port");

  // No result beat without a matching beat entering the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[0], 5))
    else $error("result beat without a matching command");

  // A saturated result carries at least one clipped component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.saturated) |->
      (result_o.result_x == SatMax || result_o.result_x == SatMin ||
       result_o.result_y == SatMax || result_o.result_y == SatMin ||
       result_o.result_z == SatMax || result_o.result_z == SatMin))
    else $error("saturated flag without a clipped component");

  // Matrix trace follows the component products of the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (36'(mat_q[0][0]) + 36'(mat_q[1][1]) + 36'(mat_q[2][2])) ==
      $past(36'(ww_q) * 36'sd3 - 36'(xx_q) - 36'(yy_q) - 36'(zz_q)))
    else $error("rotation matrix out of step with the quaternion");
`endif

endmodule
